// File: rtl/tpd_pkg.sv
// Shared types, constants and helpers for the texture pixel decoder.
// Depends on nothing; every other file imports it.
package tpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FMT_W      = 3;
  localparam int DIM_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int PAL_CNT_W  = 10;
  localparam int GATHER_W   = 24;
  localparam int GPOS_W     = 2;

  localparam logic [FMT_W-1:0] FMT_NONE      = 3'd0;
  localparam logic [FMT_W-1:0] FMT_5551      = 3'd1;
  localparam logic [FMT_W-1:0] FMT_32        = 3'd2;
  localparam logic [FMT_W-1:0] FMT_5551_IDX  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_32_IDX    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [PAL_CNT_W-1:0] PAL_LAST_5551 = 10'd511;
  localparam logic [PAL_CNT_W-1:0] PAL_LAST_32   = 10'd1023;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  // Palette entries are stored with bits 3 and 4 of their index exchanged.
  function automatic byte_t swap_bits_3_4(input byte_t v);
    byte_t r;
    r    = v;
    r[3] = v[4];
    r[4] = v[3];
    return r;
  endfunction

endpackage

// File: rtl/tpd_byte_if.sv
// Valid/ready channel carrying one source byte per transfer.
// Depends on tpd_pkg.
interface tpd_byte_if;
  import tpd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t src_byte;
  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

// File: rtl/tpd_pixel_if.sv
// Valid/ready channel carrying one decoded pixel and its end-of-frame flag.
// Depends on tpd_pkg.
interface tpd_pixel_if;
  import tpd_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_argb;
  logic   last_pixel;
  modport source (output valid, output pixel_argb, output last_pixel, input ready);
  modport sink   (input valid, input pixel_argb, input last_pixel, output ready);
endinterface

// File: rtl/tpd_cfg_if.sv
// Register write channel: valid/ready with a register index and write data.
// Depends on tpd_pkg.
interface tpd_cfg_if;
  import tpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/texture_pixel_decoder.sv
// Top level of the texture pixel decoder: byte stream in, ARGB pixels out.
// Depends on tpd_pkg and the channel interfaces tpd_byte_if, tpd_pixel_if, tpd_cfg_if.

// The decoder takes one source byte per cycle while neither the output nor a
// register write stalls it, and gives ARGB pixels through the registered
// palette RAM read and stage one, then the output register. In the indexed
// modes the first 512 or 1024 bytes of each frame fill the palette and give no
// pixel. After any register write the input stalls while the frame size is
// recomputed. The register port accepts a write in every cycle and should only
// be used while the block is idle.
module texture_pixel_decoder #(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic        clk,
  input logic        rst_n,
  tpd_byte_if.sink   in_src,
  tpd_pixel_if.source out_pix,
  tpd_cfg_if.sink    cfg_wr
);
  import tpd_pkg::*;

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

  // Configuration registers and derived frame size.
  logic [FMT_W-1:0]   format_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COUNT_W-1:0] size_r;
  logic               size_stale_r;

  // Frame control state.
  logic [PAL_CNT_W-1:0] pal_cnt_r, pal_cnt_nxt;
  logic                 loaded_r, loaded_nxt;
  logic [COUNT_W-1:0]   pix_cnt_r, pix_cnt_nxt;
  logic [GATHER_W-1:0]  gather_r, gather_nxt;
  logic [GPOS_W-1:0]    gpos_r, gpos_nxt;

  // Palette memory.
  pixel_t             pal_mem [PALETTE_ENTRIES];
  pixel_t             rd_data_r;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  pixel_t             wr_data;
  logic               rd_en;

  // Stage one and output register.
  logic   s1_valid_r, s1_lookup_r, s1_last_r;
  pixel_t s1_pix_r;
  logic   out_valid_r, out_last_r;
  pixel_t out_pix_r;

  logic   cfg_fire, in_fire, s1_move;
  logic   emit, emit_lookup, emit_last;
  pixel_t emit_pix;
  logic   pix_ready;
  pixel_t pix_val;
  byte_t  b0, b1, b2, bin;
  logic   frame_end;

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid;

  assign s1_move      = !out_valid_r || out_pix.ready;
  assign in_src.ready = (!s1_valid_r || s1_move) && !size_stale_r;
  assign in_fire      = in_src.valid && in_src.ready;

  assign bin       = in_src.src_byte;
  assign b0        = gather_r[7:0];
  assign b1        = gather_r[15:8];
  assign b2        = gather_r[23:16];
  assign frame_end = ({1'b0, pix_cnt_r} + 33'd1) >= {1'b0, size_r};

  always_comb begin
    pal_cnt_nxt = pal_cnt_r;
    loaded_nxt  = loaded_r;
    pix_cnt_nxt = pix_cnt_r;
    gather_nxt  = gather_r;
    gpos_nxt    = gpos_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    pix_ready   = 1'b0;
    pix_val     = '0;
    emit_lookup = 1'b0;
    unique case (format_r)
      FMT_5551: begin
        if (gpos_r == 2'd0) begin
          gather_nxt = {16'h0000, bin};
          gpos_nxt   = 2'd1;
        end else begin
          gather_nxt = '0;
          gpos_nxt   = '0;
          pix_ready  = 1'b1;
          pix_val    = {16'h0000,
                        (bin & 8'h83) | {b0[4:0], 2'b00},
                        (b0 & 8'hE0) | {3'b000, bin[6:2]}};
        end
      end
      FMT_32: begin
        if (gpos_r != 2'd3) begin
          gather_nxt = gather_r | ({16'h0000, bin} << {gpos_r, 3'b000});
          gpos_nxt   = gpos_r + 2'd1;
        end else begin
          gather_nxt = '0;
          gpos_nxt   = '0;
          pix_ready  = 1'b1;
          pix_val    = {8'hFF, b0, b1, b2};
        end
      end
      FMT_5551_IDX: begin
        if (loaded_r) begin
          pix_ready   = 1'b1;
          emit_lookup = 1'b1;
          rd_en       = 1'b1;
        end else begin
          if (gpos_r == 2'd0) begin
            gather_nxt = {16'h0000, bin};
            gpos_nxt   = 2'd1;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ADDR_W'(swap_bits_3_4(pal_cnt_r[8:1]));
            wr_data    = {{8{bin[7]}}, b0[4:0], 3'b000,
                          bin[1:0], b0[7:5], 3'b000, bin[6:2], 3'b000};
            gather_nxt = '0;
            gpos_nxt   = '0;
          end
          if (pal_cnt_r >= PAL_LAST_5551) begin
            pal_cnt_nxt = '0;
            loaded_nxt  = 1'b1;
          end else begin
            pal_cnt_nxt = pal_cnt_r + 10'd1;
          end
        end
      end
      FMT_32_IDX: begin
        if (loaded_r) begin
          pix_ready   = 1'b1;
          emit_lookup = 1'b1;
          rd_en       = 1'b1;
        end else begin
          if (gpos_r != 2'd3) begin
            gather_nxt = gather_r | ({16'h0000, bin} << {gpos_r, 3'b000});
            gpos_nxt   = gpos_r + 2'd1;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ADDR_W'(swap_bits_3_4(pal_cnt_r[9:2]));
            wr_data    = {bin, b0, b1, b2};
            gather_nxt = '0;
            gpos_nxt   = '0;
          end
          if (pal_cnt_r >= PAL_LAST_32) begin
            pal_cnt_nxt = '0;
            loaded_nxt  = 1'b1;
          end else begin
            pal_cnt_nxt = pal_cnt_r + 10'd1;
          end
        end
      end
      default: begin
        gather_nxt = gather_r;
      end
    endcase

    emit      = pix_ready && (size_r != '0);
    emit_last = frame_end;
    emit_pix  = pix_val;
    if (emit) begin
      if (frame_end) begin
        pix_cnt_nxt = '0;
        loaded_nxt  = 1'b0;
        pal_cnt_nxt = '0;
      end else begin
        pix_cnt_nxt = pix_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      pal_mem[wr_addr] <= wr_data;
    end
    if (in_fire && rd_en) begin
      rd_data_r <= pal_mem[bin[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r     <= FMT_NONE;
      width_r      <= '0;
      height_r     <= '0;
      size_r       <= '0;
      size_stale_r <= 1'b0;
      pal_cnt_r    <= '0;
      loaded_r     <= 1'b0;
      pix_cnt_r    <= '0;
      gather_r     <= '0;
      gpos_r       <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      size_r       <= width_r * height_r;
      size_stale_r <= cfg_fire;
      if (cfg_fire && cfg_wr.index <= REG_HEIGHT) begin
        unique case (cfg_wr.index)
          REG_FORMAT: format_r <= cfg_wr.data[FMT_W-1:0];
          REG_WIDTH:  width_r  <= cfg_wr.data;
          REG_HEIGHT: height_r <= cfg_wr.data;
          default:    format_r <= format_r;
        endcase
        pal_cnt_r <= '0;
        loaded_r  <= 1'b0;
        pix_cnt_r <= '0;
        gather_r  <= '0;
        gpos_r    <= '0;
      end else if (in_fire) begin
        pal_cnt_r <= pal_cnt_nxt;
        loaded_r  <= loaded_nxt;
        pix_cnt_r <= pix_cnt_nxt;
        gather_r  <= gather_nxt;
        gpos_r    <= gpos_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= emit;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lookup_r <= emit_lookup;
      s1_last_r   <= emit_last;
      s1_pix_r    <= emit_pix;
    end
    if (s1_move && s1_valid_r) begin
      out_pix_r  <= s1_lookup_r ? rd_data_r : s1_pix_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.pixel_argb = out_pix_r;
  assign out_pix.last_pixel = out_last_r;

endmodule
